/* sv/pcuf_pkg.sv */
// Shared types and constants for the parity-class union-find engine.
package pcuf_pkg;

  localparam int NODE_W      = 10;
  localparam int WORD_W      = 32;
  localparam int OUT_W       = 11;
  localparam int OP_W        = 2;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 16;

  // tdata bit positions of the input word
  localparam int A_LSB    = 0;
  localparam int B_LSB    = A_LSB + NODE_W;
  localparam int WORD_LSB = B_LSB + NODE_W;
  localparam int QT_BIT   = WORD_LSB + WORD_W;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_EDGE  = 2'd2,
    OP_QUERY = 2'd3
  } op_e;

  // controller -> datapath
  typedef struct packed {
    logic latch;        // capture the accepted word
    logic clr_start;    // zero the maxima, rewind the sweep counter
    logic clr_step;     // write one singleton entry, advance the counter
    logic clr_cls;      // sweep clears the class bits as well
    logic ld_write;     // store class of node a, raise its maximum to 1
    logic cls_rd_a;     // read class of node a
    logic cls_rd_b;     // read class of node b, keep class of a
    logic walk_start_a; // read link of node a
    logic walk_step;    // follow the parent link
    logic take_ra;      // keep root of a, start walk from b
    logic take_rb;      // keep root of b
    logic merge;        // hook smaller root under larger
    logic link;         // write winner size, raise class maximum
    logic q_load;       // load the result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    op_e  op;
    logic a_ok;
    logic edge_ok;
    logic sweep_last;
    logic at_root;
    logic cls_diff;
    logic out_free;
  } status_t;

endpackage

/* sv/pcuf_ctrl.sv */
// Sequencing state machine for the union-find engine.
module pcuf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  input  pcuf_pkg::status_t st_i,
  output pcuf_pkg::cmd_t    cmd_o
);
  import pcuf_pkg::*;

  typedef enum logic [8:0] {
    S_CLR   = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_DISP  = 9'b000000100,
    S_RDB   = 9'b000001000,
    S_WALKA = 9'b000010000,
    S_WALKB = 9'b000100000,
    S_MERGE = 9'b001000000,
    S_LINK  = 9'b010000000,
    S_QUERY = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   clr_cls_q, clr_cls_d;

  always_comb begin
    state_d    = state_q;
    clr_cls_d  = clr_cls_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    unique case (state_q)
      S_CLR: begin
        cmd_o.clr_step = 1'b1;
        cmd_o.clr_cls  = clr_cls_q;
        if (st_i.sweep_last) begin
          state_d   = S_IDLE;
          clr_cls_d = 1'b0;
        end
      end
      S_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DISP;
        end
      end
      S_DISP: begin
        unique case (st_i.op)
          OP_CLEAR: begin
            cmd_o.clr_start = 1'b1;
            state_d         = S_CLR;
          end
          OP_LOAD: begin
            cmd_o.ld_write = st_i.a_ok;
            state_d        = S_IDLE;
          end
          OP_EDGE: begin
            if (st_i.edge_ok) begin
              cmd_o.cls_rd_a = 1'b1;
              state_d        = S_RDB;
            end else begin
              state_d = S_IDLE;
            end
          end
          OP_QUERY: begin
            if (st_i.out_free) begin
              cmd_o.q_load = 1'b1;
              state_d      = S_IDLE;
            end else begin
              state_d = S_QUERY;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_RDB: begin
        cmd_o.cls_rd_b     = 1'b1;
        cmd_o.walk_start_a = 1'b1;
        state_d            = S_WALKA;
      end
      S_WALKA: begin
        if (st_i.cls_diff) begin
          state_d = S_IDLE;
        end else if (st_i.at_root) begin
          cmd_o.take_ra = 1'b1;
          state_d       = S_WALKB;
        end else begin
          cmd_o.walk_step = 1'b1;
        end
      end
      S_WALKB: begin
        if (st_i.at_root) begin
          cmd_o.take_rb = 1'b1;
          state_d       = S_MERGE;
        end else begin
          cmd_o.walk_step = 1'b1;
        end
      end
      S_MERGE: begin
        cmd_o.merge = 1'b1;
        state_d     = S_LINK;
      end
      S_LINK: begin
        cmd_o.link = 1'b1;
        state_d    = S_IDLE;
      end
      S_QUERY: begin
        if (st_i.out_free) begin
          cmd_o.q_load = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      clr_cls_q <= 1'b1;
    end else begin
      state_q   <= state_d;
      clr_cls_q <= clr_cls_d;
    end
  end

  // an accepted word is always dispatched next cycle
  a_accept_disp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o) |=> (state_q == S_DISP))
    else $error("accepted word not dispatched");

endmodule

/* sv/pcuf_dp.sv */
// Datapath: node memories, root walk, merge, class maxima and result register.
module pcuf_dp #(
  parameter int NODES = 1024
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [pcuf_pkg::IN_TDATA_W-1:0]       s_tdata_i,
  input  logic [pcuf_pkg::OP_W-1:0]             s_tuser_i,
  input  pcuf_pkg::cmd_t                        cmd_i,
  output pcuf_pkg::status_t                     st_o,
  output logic                                  m_tvalid_o,
  input  logic                                  m_tready_i,
  output logic [pcuf_pkg::OUT_TDATA_W-1:0]      m_tdata_o
);
  import pcuf_pkg::*;

  localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int SW = $clog2(NODES + 1);

  // node memories
  logic [IW-1:0] par_mem  [NODES];
  logic [SW-1:0] size_mem [NODES];
  logic          cls_mem  [NODES];

  logic [IW-1:0] par_rd_q;
  logic [SW-1:0] size_rd_q;
  logic          cls_rd_q;

  // latched item
  op_e           op_q;
  logic [IW-1:0] a_q, b_q;
  logic          a_ok_q, edge_ok_q, par_q, qt_q;

  // edge working registers
  logic          ca_q, diff_q;
  logic [IW-1:0] cur_q, ra_q, rb_q, win_q;
  logic [SW-1:0] sa_q, sb_q, sum_q;

  logic [SW-1:0] odd_max_q, even_max_q;
  logic [IW-1:0] cnt_q;
  logic          m_valid_q;
  logic [OUT_W-1:0] m_data_q;

  logic [NODE_W-1:0] a_in, b_in;
  logic          a_in_ok, b_in_ok;
  logic          at_root, ra_eq, swap;

  logic          lw_en, lr_en, cw_en, cr_en;
  logic [IW-1:0] lw_addr, lw_par, lr_addr, cw_addr, cr_addr;
  logic [SW-1:0] lw_size;
  logic          cw_data;

  logic          raise_en, raise_cls;
  logic [SW-1:0] raise_val;

  assign a_in    = s_tdata_i[A_LSB +: NODE_W];
  assign b_in    = s_tdata_i[B_LSB +: NODE_W];
  assign a_in_ok = (32'(a_in) < 32'(NODES));
  assign b_in_ok = (32'(b_in) < 32'(NODES));

  assign at_root = (par_rd_q == cur_q);
  assign ra_eq   = (ra_q == rb_q);
  assign swap    = (sa_q < sb_q);

  // link memory write
  always_comb begin
    lw_en   = 1'b0;
    lw_addr = cnt_q;
    lw_par  = cnt_q;
    lw_size = SW'(1);
    priority if (cmd_i.clr_step) begin
      lw_en = 1'b1;
    end else if (cmd_i.merge && !ra_eq) begin
      lw_en   = 1'b1;
      lw_addr = swap ? ra_q : rb_q;
      lw_par  = swap ? rb_q : ra_q;
      lw_size = swap ? sa_q : sb_q;
    end else if (cmd_i.link && diff_q) begin
      lw_en   = 1'b1;
      lw_addr = win_q;
      lw_par  = win_q;
      lw_size = sum_q;
    end
  end

  // link memory read: next node on the walk
  always_comb begin
    lr_en   = 1'b1;
    lr_addr = par_rd_q;
    priority if (cmd_i.walk_start_a) begin
      lr_addr = a_q;
    end else if (cmd_i.take_ra) begin
      lr_addr = b_q;
    end else if (cmd_i.walk_step) begin
      lr_addr = par_rd_q;
    end else begin
      lr_en = 1'b0;
    end
  end

  // class memory
  always_comb begin
    cw_en   = 1'b0;
    cw_addr = cnt_q;
    cw_data = 1'b0;
    priority if (cmd_i.clr_step) begin
      cw_en = cmd_i.clr_cls;
    end else if (cmd_i.ld_write) begin
      cw_en   = 1'b1;
      cw_addr = a_q;
      cw_data = par_q;
    end
  end

  assign cr_en   = cmd_i.cls_rd_a | cmd_i.cls_rd_b;
  assign cr_addr = cmd_i.cls_rd_b ? b_q : a_q;

  always_ff @(posedge clk_i) begin
    if (lw_en) begin
      par_mem[lw_addr]  <= lw_par;
      size_mem[lw_addr] <= lw_size;
    end
    if (lr_en) begin
      par_rd_q  <= par_mem[lr_addr];
      size_rd_q <= size_mem[lr_addr];
    end
    if (cw_en) cls_mem[cw_addr] <= cw_data;
    if (cr_en) cls_rd_q <= cls_mem[cr_addr];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q      <= op_e'(s_tuser_i);
      a_q       <= IW'(a_in);
      b_q       <= IW'(b_in);
      a_ok_q    <= a_in_ok;
      edge_ok_q <= a_in_ok & b_in_ok;
      par_q     <= ^s_tdata_i[WORD_LSB +: WORD_W];
      qt_q      <= s_tdata_i[QT_BIT];
    end
    if (cmd_i.cls_rd_b) ca_q <= cls_rd_q;
    if (lr_en) cur_q <= lr_addr;
    if (cmd_i.take_ra) begin
      ra_q <= cur_q;
      sa_q <= size_rd_q;
    end
    if (cmd_i.take_rb) begin
      rb_q <= cur_q;
      sb_q <= size_rd_q;
    end
    if (cmd_i.merge) begin
      win_q  <= swap ? rb_q : ra_q;
      sum_q  <= ra_eq ? sa_q : sa_q + sb_q;
      diff_q <= !ra_eq;
    end
    if (cmd_i.q_load) begin
      m_data_q <= (par_q == qt_q) ? OUT_W'(even_max_q) : OUT_W'(odd_max_q);
    end
  end

  // class maxima
  always_comb begin
    raise_en  = cmd_i.ld_write | cmd_i.link;
    raise_cls = cmd_i.ld_write ? par_q : ca_q;
    raise_val = cmd_i.ld_write ? SW'(1) : sum_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      odd_max_q  <= '0;
      even_max_q <= '0;
      cnt_q      <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.clr_start) begin
        odd_max_q  <= '0;
        even_max_q <= '0;
      end else if (raise_en) begin
        if (raise_cls && (raise_val > odd_max_q)) odd_max_q <= raise_val;
        if (!raise_cls && (raise_val > even_max_q)) even_max_q <= raise_val;
      end
      if (cmd_i.clr_start) cnt_q <= '0;
      else if (cmd_i.clr_step) cnt_q <= cnt_q + IW'(1);
      if (cmd_i.q_load) m_valid_q <= 1'b1;
      else if (m_tready_i) m_valid_q <= 1'b0;
    end
  end

  always_comb begin
    st_o.op         = op_q;
    st_o.a_ok       = a_ok_q;
    st_o.edge_ok    = edge_ok_q;
    st_o.sweep_last = (cnt_q == IW'(NODES - 1));
    st_o.at_root    = at_root;
    st_o.cls_diff   = (ca_q != cls_rd_q);
    st_o.out_free   = !m_valid_q || m_tready_i;
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = OUT_TDATA_W'(m_data_q);

  a_root_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.take_ra || cmd_i.take_rb) |-> at_root)
    else $error("root captured off a root");

  a_max_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.clr_start |=>
      (odd_max_q >= $past(odd_max_q)) && (even_max_q >= $past(even_max_q)))
    else $error("class maximum fell without a clear");

  a_sum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.link |-> (sum_q != '0) && (32'(sum_q) <= 32'(NODES)))
    else $error("merged set size out of range");

endmodule

/* sv/parity_class_union_find.sv */
// Top level of the parity-class union-find engine.
//
//  channel   dir  tdata (low bit up)                              tuser
//  s_axis    in   node_a[9:0] node_b[19:10] data_word[51:20]      opcode[1:0]
//                 query_type[52], zero pad [55:53]
//  m_axis    out  max_size[10:0], zero pad [15:11]                -
//
// One word is in flight at a time; the next is taken once the current one
// retires, even while a query result still waits in the output register.
// A query waits while the output register is held. An edge walks from each
// endpoint to its root, a walk length of at most log2(NODES), with one
// link-memory read per step.
// Clear sweeps the link memory one entry a cycle.
// After reset the same sweep, also clearing the class bits, runs with
// s_axis_tready low.
module parity_class_union_find #(
  parameter int NODES = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // node_a [9:0], node_b [19:10], data_word [51:20], query_type [52]
  input  logic [pcuf_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // opcode [1:0]
  input  logic [pcuf_pkg::OP_W-1:0]          s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // max_size [10:0]
  output logic [pcuf_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
  import pcuf_pkg::*;

  cmd_t    cmd;
  status_t st;

  // controller: owns the handshake on the slave side and sequences each op
  pcuf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // datapath: node memories, walk and merge logic, maxima, result register
  pcuf_dp #(
    .NODES (NODES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .cmd_i      (cmd),
    .st_o       (st),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata)
  );

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the parity-class union-find engine.
module tb_top;
  import pcuf_pkg::*;

  localparam int NODES    = 1024;
  localparam int MAX_GAP  = 80;   // longest idle stretch on either side
  localparam int EDGE_MAX = 27;   // budget for the deepest edge, both root walks at log2(NODES)
  localparam int HOLD_LEN = 300;  // long receiver hold-off
  localparam int HOLD_GAP = 500;  // words between hold-offs
  localparam int N_WORDS  = 1325;

  typedef struct {
    op_e               op;
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
    logic [WORD_W-1:0] w;
    logic              qt;
  } uf_word_t;

  logic                   clk_i  = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [OP_W-1:0]        s_axis_tuser  = OP_CLEAR;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // mirror of the engine state
  logic [NODE_W-1:0] link_of  [NODES];
  logic [OUT_W-1:0]  grp_size [NODES];
  logic              cls_of   [NODES];
  logic [OUT_W-1:0]  odd_peak;
  logic [OUT_W-1:0]  even_peak;

  uf_word_t         pending_words [$];
  logic [OUT_W-1:0] max_size_due  [$];

  uf_word_t drv_word;
  int       src_gap    = 0;
  logic     src_calm   = 1'b0;
  int       sink_wait  = 0;
  logic     sink_calm  = 1'b0;
  int       hold_left  = 0;
  int       next_hold  = 400;
  logic     s_took     = 1'b0;
  int       words_in   = 0;
  int       mismatches = 0;
  int       n_clear    = 0;
  longint   cycles     = 0;
  longint   cycle_limit = 64'd4_000_000;

  parity_class_union_find #(.NODES(NODES)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // mostly short gaps, the odd long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, MAX_GAP);
  endfunction

  function automatic logic [WORD_W-1:0] word_with_parity(logic par);
    logic [WORD_W-1:0] w;
    int pos;
    w = $urandom;
    pos = $urandom_range(0, WORD_W - 1);
    if ((^w) != par) w[pos] = ~w[pos];
    return w;
  endfunction

  task automatic push_word(op_e op, int a, int b, logic [WORD_W-1:0] w, int qt);
    uf_word_t u;
    u.op = op;
    u.a  = a[NODE_W-1:0];
    u.b  = b[NODE_W-1:0];
    u.w  = w;
    u.qt = qt[0];
    if (op == OP_CLEAR) n_clear++;
    pending_words = {pending_words, u};
  endtask

  // every node its own singleton, maxima zeroed; classes untouched
  task automatic make_singletons();
    for (int i = 0; i < NODES; i++) begin
      link_of[i]  = i[NODE_W-1:0];
      grp_size[i] = OUT_W'(1);
    end
    odd_peak  = '0;
    even_peak = '0;
  endtask

  task automatic raise_peak(logic cls, logic [OUT_W-1:0] sz);
    if (cls) begin
      if (sz > odd_peak) odd_peak = sz;
    end else begin
      if (sz > even_peak) even_peak = sz;
    end
  endtask

  function automatic logic [NODE_W-1:0] root_of_node(logic [NODE_W-1:0] n);
    logic [NODE_W-1:0] r;
    int steps;
    r = n;
    steps = 0;
    while (link_of[r] != r && steps < NODES) begin
      r = link_of[r];
      steps++;
    end
    return r;
  endfunction

  // apply one accepted word to the mirror; a query queues its max_size
  task automatic predict_max_size(uf_word_t u);
    logic [NODE_W-1:0] ra, rb, t;
    case (u.op)
      OP_CLEAR: make_singletons();
      OP_LOAD: begin
        cls_of[u.a] = ^u.w;
        raise_peak(cls_of[u.a], OUT_W'(1));
      end
      OP_EDGE: begin
        if (cls_of[u.a] == cls_of[u.b]) begin
          ra = root_of_node(u.a);
          rb = root_of_node(u.b);
          if (ra != rb) begin
            // larger set wins, a tie keeps the root of node a
            if (grp_size[ra] < grp_size[rb]) begin
              t  = ra;
              ra = rb;
              rb = t;
            end
            link_of[rb]  = ra;
            grp_size[ra] = grp_size[ra] + grp_size[rb];
          end
          raise_peak(cls_of[u.a], grp_size[ra]);
        end
      end
      default: max_size_due = {max_size_due, (((^u.w) == u.qt) ? even_peak : odd_peak)};
    endcase
  endtask

  // sender: next word or a gap, changed on the falling edge
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || s_took)) begin
      if (src_gap != 0 || pending_words.size() == 0) begin
        s_axis_tvalid <= 1'b0;
        if (src_gap != 0) src_gap <= src_gap - 1;
      end else begin
        drv_word = pending_words.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, drv_word.qt, drv_word.w, drv_word.b, drv_word.a};
        s_axis_tuser  <= drv_word.op;
        src_gap <= src_calm ? 0 : pick_gap();
        if ($urandom_range(0, 149) == 0) src_calm <= ~src_calm;
      end
    end
  end

  // long hold-off of the receiver, counted here
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (words_in == next_hold) begin
      hold_left <= HOLD_LEN;
      next_hold <= next_hold + HOLD_GAP;
    end
  end

  // receiver: random stalls, calm stretches, and the hold-off above
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
    end else if (sink_wait != 0) begin
      m_axis_tready <= 1'b0;
      sink_wait <= sink_wait - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if (!sink_calm && $urandom_range(0, 3) == 0) sink_wait <= pick_gap();
      if ($urandom_range(0, 199) == 0) sink_calm <= ~sink_calm;
    end
  end

  // monitor: check results first, then predict from the accepted word
  always @(posedge clk_i) begin
    uf_word_t u;
    logic [OUT_W-1:0] due;
    s_took <= s_axis_tvalid && s_axis_tready;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (max_size_due.size() == 0) begin
        $error("max_size: expected none, got %0d", m_axis_tdata[OUT_W-1:0]);
        mismatches++;
      end else begin
        due = max_size_due.pop_front();
        if (m_axis_tdata[OUT_W-1:0] !== due) begin
          $error("max_size: expected %0d, got %0d", due, m_axis_tdata[OUT_W-1:0]);
          mismatches++;
        end
        if (m_axis_tdata[OUT_TDATA_W-1:OUT_W] !== '0) begin
          $error("pad: expected 0, got %0h", m_axis_tdata[OUT_TDATA_W-1:OUT_W]);
          mismatches++;
        end
      end
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      u.op = op_e'(s_axis_tuser);
      u.a  = s_axis_tdata[A_LSB +: NODE_W];
      u.b  = s_axis_tdata[B_LSB +: NODE_W];
      u.w  = s_axis_tdata[WORD_LSB +: WORD_W];
      u.qt = s_axis_tdata[QT_BIT];
      predict_max_size(u);
      words_in <= words_in + 1;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == cycle_limit) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    int pick, span, base, bias, steps, a, b, t;
    logic tree;
    make_singletons();
    for (int i = 0; i < NODES; i++) cls_of[i] = 1'b0;

    // directed: empty maxima, same-node edge, class mismatch, tie, same set,
    // reload after edges, clear keeping classes, extreme nodes and words
    push_word(OP_QUERY, 0, 0, 32'h0000_0000, 1'b0);
    push_word(OP_QUERY, 0, 0, 32'hFFFF_FFFF, 1'b1);
    push_word(OP_EDGE, 0, 0, 32'h0, 1'b0);
    push_word(OP_LOAD, 1023, 1023, 32'h0000_0001, 1'b1);
    push_word(OP_LOAD, 0, 0, 32'hFFFF_FFFF, 1'b0);
    push_word(OP_EDGE, 0, 1023, 32'h0, 1'b0);
    push_word(OP_LOAD, 1022, 0, 32'h8000_0000, 1'b0);
    push_word(OP_EDGE, 1023, 1022, 32'hFFFF_FFFF, 1'b1);
    push_word(OP_EDGE, 1022, 1023, 32'h0, 1'b0);
    push_word(OP_QUERY, 0, 0, 32'h0000_0001, 1'b1);
    push_word(OP_QUERY, 1023, 1023, 32'h0000_0001, 1'b0);
    push_word(OP_LOAD, 1022, 0, 32'h0000_0003, 1'b0);
    push_word(OP_EDGE, 1022, 0, 32'h0, 1'b0);
    push_word(OP_EDGE, 1023, 0, 32'h0, 1'b0);
    push_word(OP_QUERY, 0, 0, 32'h0000_0007, 1'b0);
    push_word(OP_LOAD, 512, 0, 32'hAAAA_AAAA, 1'b0);
    push_word(OP_LOAD, 511, 0, 32'h5555_5555, 1'b0);
    push_word(OP_EDGE, 511, 512, 32'h0, 1'b0);
    push_word(OP_EDGE, 0, 511, 32'h0, 1'b0);
    push_word(OP_QUERY, 0, 0, 32'h0, 1'b0);
    push_word(OP_CLEAR, 1023, 1023, 32'hFFFF_FFFF, 1'b1);
    push_word(OP_QUERY, 0, 0, 32'h0, 1'b0);
    push_word(OP_QUERY, 0, 0, 32'h1, 1'b0);
    push_word(OP_EDGE, 1023, 1022, 32'h0, 1'b0);
    push_word(OP_QUERY, 0, 0, 32'hFFFF_FFFF, 1'b0);

    // random episodes: optional clear, loads in a window, then mostly edges
    // inside it with queries between; now and then a burst of pure noise
    while (pending_words.size() < N_WORDS) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat (8) push_word(op_e'($urandom_range(0, 3)), $urandom_range(0, NODES - 1),
                             $urandom_range(0, NODES - 1), $urandom, $urandom_range(0, 1));
      end else begin
        if ($urandom_range(0, 2) == 0)
          push_word(OP_CLEAR, $urandom_range(0, NODES - 1), $urandom_range(0, NODES - 1),
                    $urandom, $urandom_range(0, 1));
        pick = $urandom_range(0, 19);
        if (pick < 12)      span = $urandom_range(2, 12);
        else if (pick < 19) span = $urandom_range(13, 64);
        else                span = $urandom_range(65, 300);
        base = $urandom_range(0, NODES - span);
        bias = $urandom_range(0, 2);  // all even, all odd or mixed classes
        repeat ((span < 24) ? span : 24)
          push_word(OP_LOAD, base + $urandom_range(0, span - 1), $urandom_range(0, NODES - 1),
                    word_with_parity((bias == 2) ? 1'($urandom_range(0, 1)) : bias[0]),
                    $urandom_range(0, 1));
        // tree episodes link node i to an earlier node of the window
        tree  = (span > 12) && ($urandom_range(0, 1) == 1);
        steps = tree ? span - 1 : $urandom_range(span, 3 * span);
        for (int i = 1; i <= steps && pending_words.size() < N_WORDS; i++) begin
          pick = $urandom_range(0, 19);
          if (pick < 14) begin
            a = tree ? base + i : base + $urandom_range(0, span - 1);
            b = tree ? base + $urandom_range(0, i - 1) : base + $urandom_range(0, span - 1);
            if ($urandom_range(0, 1) == 1) begin
              t = a;
              a = b;
              b = t;
            end
            push_word(OP_EDGE, a, b, $urandom, $urandom_range(0, 1));
          end else if (pick < 18) begin
            push_word(OP_QUERY, $urandom_range(0, NODES - 1), $urandom_range(0, NODES - 1),
                      $urandom, $urandom_range(0, 1));
          end else if (pick == 18) begin
            push_word(OP_LOAD, base + $urandom_range(0, span - 1), $urandom_range(0, NODES - 1),
                      $urandom, $urandom_range(0, 1));
          end else begin
            push_word(OP_EDGE, base + $urandom_range(0, span - 1), $urandom_range(0, NODES - 1),
                      $urandom, $urandom_range(0, 1));
          end
        end
      end
    end

    // worst case: every word as slow as an edge with both sides at their
    // longest gap, plus every clear sweep, the reset sweep and the hold-offs
    cycle_limit = 4 * (longint'(NODES + 2) * (n_clear + 2)
                  + longint'(pending_words.size()) * (EDGE_MAX + 2 * MAX_GAP + 4)
                  + longint'(pending_words.size() / HOLD_GAP + 1) * HOLD_LEN + 2000);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_words.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (max_size_due.size() != 0) @(posedge clk_i);
    // a clear may still be sweeping; catch any stray word after it
    repeat (NODES + 40) @(posedge clk_i);

    if (mismatches == 0 && max_size_due.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

/* parity_class_union_find.f */
sv/pcuf_pkg.sv
sv/pcuf_ctrl.sv
sv/pcuf_dp.sv
sv/parity_class_union_find.sv
sim/tb_top.sv
